@@ src/imufd_pkg.sv @@
// Shared types and constants for the IMU frame decoder.
`default_nettype none
package imufd_pkg;
    localparam logic [7:0] HEAD_A = 8'h55;
    localparam logic [7:0] HEAD_B = 8'h51;
    localparam int FRAME_LEN = 44;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [26:0] RATE_K = 27'd73204415;
    localparam logic [11:0] ACCEL_K = 12'd3136;
    // floor(n / 10) as (n * DIV10_K) >> 30, exact for any n below 2^27.
    localparam logic [26:0] DIV10_K = 27'd107374183;

    // Raw frame words handed from the front part to the back part.
    typedef struct packed {
        logic signed [15:0] ax, ay, az;
        logic signed [15:0] gx, gy, gz;
        logic signed [15:0] roll, pitch, yaw;
    } t_raw;

    typedef enum logic [3:0] {
        ST_IDLE, ST_AXIS, ST_CORDIC, ST_MUL1, ST_MUL2, ST_SUM, ST_DONE
    } t_bstate;

    function automatic logic signed [17:0] atan_of(input logic [3:0] i);
        logic signed [17:0] v;
        begin
            unique case (i)
                4'd0: v = 18'sd16384;
                4'd1: v = 18'sd9672;
                4'd2: v = 18'sd5110;
                4'd3: v = 18'sd2594;
                4'd4: v = 18'sd1302;
                4'd5: v = 18'sd652;
                4'd6: v = 18'sd326;
                4'd7: v = 18'sd163;
                4'd8: v = 18'sd81;
                4'd9: v = 18'sd41;
                4'd10: v = 18'sd20;
                4'd11: v = 18'sd10;
                4'd12: v = 18'sd5;
                4'd13: v = 18'sd3;
                default: v = 18'sd1;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

@@ src/imufd_front.sv @@
// Header sync and frame capture; emits the raw words of a finished frame.
`default_nettype none
module imufd_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire [7:0]      i_rx_byte,
    input  wire            i_q_full,
    output logic           o_full,
    output logic           o_q_push,
    output imufd_pkg::t_raw o_raw
);
    logic [5:0]      r_pos;
    imufd_pkg::t_raw r_raw;
    logic            take;

    assign o_full = i_q_full;
    assign take = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (take) begin
            priority if (r_pos == 6'd0) begin
                r_pos <= (i_rx_byte == imufd_pkg::HEAD_A) ? 6'd1 : 6'd0;
            end else if (r_pos == 6'd1) begin
                if (i_rx_byte == imufd_pkg::HEAD_B) r_pos <= 6'd2;
                else r_pos <= (i_rx_byte == imufd_pkg::HEAD_A) ? 6'd1 : 6'd0;
            end else if (r_pos >= 6'(imufd_pkg::FRAME_LEN - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    // Keep only the bytes that carry counts; each word arrives low byte first.
    always_ff @(posedge i_clk) begin
        if (take) begin
            unique case (r_pos)
                6'd2:  r_raw.ax[7:0]     <= i_rx_byte;
                6'd3:  r_raw.ax[15:8]    <= i_rx_byte;
                6'd4:  r_raw.ay[7:0]     <= i_rx_byte;
                6'd5:  r_raw.ay[15:8]    <= i_rx_byte;
                6'd6:  r_raw.az[7:0]     <= i_rx_byte;
                6'd7:  r_raw.az[15:8]    <= i_rx_byte;
                6'd13: r_raw.gx[7:0]     <= i_rx_byte;
                6'd14: r_raw.gx[15:8]    <= i_rx_byte;
                6'd15: r_raw.gy[7:0]     <= i_rx_byte;
                6'd16: r_raw.gy[15:8]    <= i_rx_byte;
                6'd17: r_raw.gz[7:0]     <= i_rx_byte;
                6'd18: r_raw.gz[15:8]    <= i_rx_byte;
                6'd24: r_raw.roll[7:0]   <= i_rx_byte;
                6'd25: r_raw.roll[15:8]  <= i_rx_byte;
                6'd26: r_raw.pitch[7:0]  <= i_rx_byte;
                6'd27: r_raw.pitch[15:8] <= i_rx_byte;
                6'd28: r_raw.yaw[7:0]    <= i_rx_byte;
                6'd29: r_raw.yaw[15:8]   <= i_rx_byte;
                default: begin
                end
            endcase
        end
    end

    // Yaw is complete long before the last byte; header checks sit at 0 and 1 only.
    assign o_q_push = take && r_pos == 6'(imufd_pkg::FRAME_LEN - 1);
    assign o_raw = r_raw;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 6'd44) else $error("position out of range");
    a_push_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> r_pos == 6'd0) else $error("frame end did not rewind");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_pos == 6'd0 && i_rx_byte != imufd_pkg::HEAD_A |=> r_pos == 6'd0)
        else $error("bad header accepted");
endmodule
`default_nettype wire

@@ src/imufd_queue.sv @@
// Two-entry queue of raw frames between the front and back parts.
`default_nettype none
module imufd_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire imufd_pkg::t_raw i_data,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output imufd_pkg::t_raw o_data
);
    imufd_pkg::t_raw r_mem [0:1];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) == (r_wp == r_rp)) else $error("pointer mismatch");
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty) else $error("entry lost");
endmodule
`default_nettype wire

@@ src/imufd_back.sv @@
// Scaling, shared CORDIC and quaternion products for one frame at a time.
`default_nettype none
module imufd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  wire imufd_pkg::t_raw i_raw,
    output logic             o_pop,
    output logic             o_empty,
    input  wire              i_pop,
    output logic signed [24:0] o_accel_x, o_accel_y, o_accel_z,
    output logic signed [22:0] o_rate_x, o_rate_y, o_rate_z,
    output logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z
);
    imufd_pkg::t_bstate r_st, n_st;
    imufd_pkg::t_raw    r_raw;
    logic [3:0]  r_i;
    logic [1:0]  r_k;
    logic [27:0] r_amul;
    logic signed [33:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic signed [33:0] r_c [0:2];
    logic signed [33:0] r_s [0:2];
    logic signed [33:0] r_p [0:7];
    logic signed [33:0] r_q [0:7];
    logic signed [24:0] r_ax, r_ay, r_az;
    logic signed [22:0] r_gx, r_gy, r_gz;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    logic signed [15:0] acnt, gcnt, ang;
    logic [15:0] amag, gmag;
    logic [27:0] amul;
    logic [55:0] adiv;
    logic [42:0] gmul;
    logic [24:0] aq;
    logic [22:0] gq;
    logic signed [33:0] dx, dy;
    logic signed [33:0] ma [0:7];
    logic signed [33:0] mb [0:7];

    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b;
            return p[63:30];
        end
    endfunction

    function automatic logic signed [15:0] q14(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] r;
        begin
            t = 35'(v) + 35'sd32768;
            r = t[34:16];
            if (r > 19'sd16384) r = 19'sd16384;
            if (r < -19'sd16384) r = -19'sd16384;
            return r[15:0];
        end
    endfunction

    // Axis k selects one accel count, one rate count and one Euler angle.
    always_comb begin
        unique case (r_k)
            2'd0: begin acnt = r_raw.ax; gcnt = r_raw.gx; ang = r_raw.roll; end
            2'd1: begin acnt = r_raw.ay; gcnt = r_raw.gy; ang = r_raw.pitch; end
            default: begin acnt = r_raw.az; gcnt = r_raw.gz; ang = r_raw.yaw; end
        endcase
        amag = acnt[15] ? 16'(-acnt) : acnt;
        gmag = gcnt[15] ? 16'(-gcnt) : gcnt;
        amul = 28'(amag) * 28'(imufd_pkg::ACCEL_K) + 28'd5;
        // Divide the registered product by ten with a reciprocal multiply.
        adiv = 56'(r_amul) * 56'(imufd_pkg::DIV10_K);
        aq = adiv[54:30];
        gmul = 43'(gmag) * 43'(imufd_pkg::RATE_K) + 43'd524288;
        gq = gmul[42:20];
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
    end

    // Three-factor terms: w,x,y,z each as two products.
    always_comb begin
        ma[0] = r_c[0]; mb[0] = r_c[1];
        ma[1] = r_s[0]; mb[1] = r_s[1];
        ma[2] = r_s[0]; mb[2] = r_c[1];
        ma[3] = r_c[0]; mb[3] = r_s[1];
        ma[4] = r_c[0]; mb[4] = r_s[1];
        ma[5] = r_s[0]; mb[5] = r_c[1];
        ma[6] = r_c[0]; mb[6] = r_c[1];
        ma[7] = r_s[0]; mb[7] = r_s[1];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            imufd_pkg::ST_IDLE:   if (!i_empty) n_st = imufd_pkg::ST_AXIS;
            imufd_pkg::ST_AXIS:   n_st = imufd_pkg::ST_CORDIC;
            imufd_pkg::ST_CORDIC: if (r_i == 4'd15)
                                      n_st = (r_k == 2'd2) ? imufd_pkg::ST_MUL1
                                                           : imufd_pkg::ST_AXIS;
            imufd_pkg::ST_MUL1:   n_st = imufd_pkg::ST_MUL2;
            imufd_pkg::ST_MUL2:   n_st = imufd_pkg::ST_SUM;
            imufd_pkg::ST_SUM:    n_st = imufd_pkg::ST_DONE;
            imufd_pkg::ST_DONE:   if (i_pop) n_st = imufd_pkg::ST_IDLE;
            default:              n_st = imufd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = r_st == imufd_pkg::ST_IDLE && !i_empty;
        o_empty = r_st != imufd_pkg::ST_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= imufd_pkg::ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            imufd_pkg::ST_IDLE: begin
                r_raw <= i_raw;
                r_k <= 2'd0;
            end
            imufd_pkg::ST_AXIS: begin
                r_x <= imufd_pkg::CORDIC_START;
                r_y <= '0;
                r_z <= 18'(ang);
                r_i <= '0;
                r_amul <= amul;
                unique case (r_k)
                    2'd0: r_gx <= gcnt[15] ? -gq : gq;
                    2'd1: r_gy <= gcnt[15] ? -gq : gq;
                    default: r_gz <= gcnt[15] ? -gq : gq;
                endcase
            end
            imufd_pkg::ST_CORDIC: begin
                if (!r_z[17]) begin
                    r_x <= r_x - dx; r_y <= r_y + dy;
                    r_z <= r_z - imufd_pkg::atan_of(r_i);
                end else begin
                    r_x <= r_x + dx; r_y <= r_y - dy;
                    r_z <= r_z + imufd_pkg::atan_of(r_i);
                end
                r_i <= r_i + 4'd1;
                // Finish the acceleration of this axis on the first step.
                if (r_i == 4'd0) begin
                    unique case (r_k)
                        2'd0: r_ax <= acnt[15] ? -aq : aq;
                        2'd1: r_ay <= acnt[15] ? -aq : aq;
                        default: r_az <= acnt[15] ? -aq : aq;
                    endcase
                end
                if (r_i == 4'd15) begin
                    r_c[r_k] <= (!r_z[17]) ? r_x - dx : r_x + dx;
                    r_s[r_k] <= (!r_z[17]) ? r_y + dy : r_y - dy;
                    if (r_k != 2'd2) r_k <= r_k + 2'd1;
                end
            end
            imufd_pkg::ST_MUL1: begin
                for (int j = 0; j < 8; j++) r_p[j] <= mul30(ma[j], mb[j]);
            end
            imufd_pkg::ST_MUL2: begin
                r_q[0] <= mul30(r_p[0], r_c[2]); r_q[1] <= mul30(r_p[1], r_s[2]);
                r_q[2] <= mul30(r_p[2], r_c[2]); r_q[3] <= mul30(r_p[3], r_s[2]);
                r_q[4] <= mul30(r_p[4], r_c[2]); r_q[5] <= mul30(r_p[5], r_s[2]);
                r_q[6] <= mul30(r_p[6], r_s[2]); r_q[7] <= mul30(r_p[7], r_c[2]);
            end
            imufd_pkg::ST_SUM: begin
                r_qw <= q14(r_q[0] + r_q[1]);
                r_qx <= q14(r_q[2] - r_q[3]);
                r_qy <= q14(r_q[4] + r_q[5]);
                r_qz <= q14(r_q[6] - r_q[7]);
            end
            default: begin
            end
        endcase
    end

    assign o_accel_x = r_ax; assign o_accel_y = r_ay; assign o_accel_z = r_az;
    assign o_rate_x = r_gx; assign o_rate_y = r_gy; assign o_rate_z = r_gz;
    assign o_quat_w = r_qw; assign o_quat_x = r_qx;
    assign o_quat_y = r_qy; assign o_quat_z = r_qz;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_quat_w)) else $error("result moved");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == imufd_pkg::ST_IDLE) else $error("pop while busy");
    a_cordic_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == imufd_pkg::ST_CORDIC |-> r_k != 2'd3) else $error("axis index overflow");
endmodule
`default_nettype wire

@@ src/imu_frame_decoder.sv @@
// Top level of the IMU frame decoder: byte front end, frame queue, math back end.
`default_nettype none
// Takes one serial byte per beat, syncs on 0x55 0x51 and captures a 44-byte
// frame. A byte is accepted every cycle while full is low; the front end
// only stalls when the two-entry frame queue is full. Each completed frame
// yields one beat with acceleration (Q9.16 m/s^2), angular rate (Q7.16
// rad/s) and a Q2.14 quaternion. For each frame the back end pops the frame,
// runs, for each of the three axes, the scaling and the shared 16-step CORDIC
// on its Euler angle, forms the quaternion products and sums, and holds the
// result beat until it is popped. It takes no new frame until then, and it
// is slower than a steady byte stream, so the stream fills the queue and
// full rises until the back end catches up; an unpopped result stalls the
// back end and, in turn, input.
// Checksums and other frame bytes are ignored.
module imu_frame_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_rx_byte,
    output logic        empty,
    input  wire         pop,
    output logic signed [24:0] o_accel_x,
    output logic signed [24:0] o_accel_y,
    output logic signed [24:0] o_accel_z,
    output logic signed [22:0] o_rate_x,
    output logic signed [22:0] o_rate_y,
    output logic signed [22:0] o_rate_z,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);
    imufd_pkg::t_raw f_raw, q_raw;
    logic f_push, q_full, q_empty, b_pop;

    // Capture bytes and hand complete frames to the queue.
    imufd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_rx_byte(i_rx_byte),
        .i_q_full(q_full), .o_full(full), .o_q_push(f_push), .o_raw(f_raw)
    );

    // Decouple byte capture from the slow math.
    imufd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push), .i_data(f_raw),
        .o_full(q_full), .i_pop(b_pop), .o_empty(q_empty), .o_data(q_raw)
    );

    // Scale and convert one frame, hold the result until popped.
    imufd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .i_raw(q_raw),
        .o_pop(b_pop), .o_empty(empty), .i_pop(pop),
        .o_accel_x(o_accel_x), .o_accel_y(o_accel_y), .o_accel_z(o_accel_z),
        .o_rate_x(o_rate_x), .o_rate_y(o_rate_y), .o_rate_z(o_rate_z),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full) else $error("frame dropped");
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty |=> empty) else $error("result repeated");
    a_bpop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> !q_empty) else $error("pop from empty queue");
endmodule
`default_nettype wire
